// ===== rtl/core/ccf_pkg.sv =====
// types, constants and the crc-16 byte fold shared by the crc16 command framer
// no dependencies; compile first
package ccf_pkg;

  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam int unsigned MAX_RESULTS = 5;
  localparam int unsigned CNT_W       = 3;

  // operation codes
  localparam logic OP_TRANSMIT = 1'b0;
  localparam logic OP_CHECK    = 1'b1;

  // result kinds
  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // held byte fill level in check mode
  localparam logic [1:0] HELD_FULL = 2'd2;

  // register index decode
  localparam logic REG_FRAME_HEADER = 1'b0;

  // all results caused by one input beat, slot 0 goes out first
  typedef struct packed {
    logic [CNT_W-1:0]             count;
    logic                         kind;
    logic                         match;
    logic [MAX_RESULTS-1:0][7:0]  bytes;
  } ccf_bundle_t;

  // one byte of crc-16/xmodem, msb first
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/ccf_in_if.sv =====
// input beat channel of the crc16 command framer: valid/ready plus frame byte fields
// no dependencies
interface ccf_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, output operation, output data_byte,
                  output first_byte, output last_byte, input ready);
  modport sink   (input valid, input operation, input data_byte,
                  input first_byte, input last_byte, output ready);
endinterface

// ===== rtl/core/ccf_out_if.sv =====
// result beat channel of the crc16 command framer: valid/ready plus result fields
// no dependencies
interface ccf_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] out_byte;
  logic       crc_match;
  logic       end_of_run;

  modport source (output valid, output result_kind, output out_byte,
                  output crc_match, output end_of_run, input ready);
  modport sink   (input valid, input result_kind, input out_byte,
                  input crc_match, input end_of_run, output ready);
endinterface

// ===== rtl/core/crc16_command_framer_unit.sv =====
// top level of the crc16 command framer: apb register, frame state and result buffer
// depends on ccf_pkg, ccf_in_if, ccf_out_if, ccf_apb_regs, ccf_framer, ccf_result_buf
//
// builds and checks crc-16/xmodem frames (poly 0x1021, init 0, msb first) one byte a
// beat. operation 0 sends: a first byte is preceded by the two frame_header bytes (high
// first), every payload byte passes through, and a last byte is followed by the crc
// high and low bytes. operation 1 checks: the last two bytes of a frame are the crc of
// the bytes before them, and the last byte gives one verdict beat (frames under two
// bytes pass); other check bytes give no result. a sent byte is folded into the crc in
// the cycle it is accepted, a checked byte when the byte two after it is accepted. all
// results of a beat (none up to five) go to the result buffer, which sends one beat
// per cycle while out_ready is high. a new input beat is taken in the same cycle as
// the buffer's final beat leaves, so with out_ready high an input that makes at most
// one result runs at one beat per clock. frame_header is at config byte address 0.
module crc16_command_framer_unit (
  input  logic         clk,
  input  logic         rst_n,
  ccf_in_if.sink       in_bus,
  ccf_out_if.source    out_bus,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import ccf_pkg::*;

  logic        in_accept;
  logic        can_load;
  logic [15:0] frame_header;
  ccf_bundle_t bundle;

  // input beat accepted whenever the buffer is empty or draining its final beat
  assign in_bus.ready = can_load;
  assign in_accept    = in_bus.valid && can_load;

  ccf_apb_regs u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (cfg_psel),
    .penable      (cfg_penable),
    .pwrite       (cfg_pwrite),
    .paddr        (cfg_paddr),
    .pwdata       (cfg_pwdata),
    .prdata       (cfg_prdata),
    .pready       (cfg_pready),
    .frame_header (frame_header)
  );

  // crc and held-byte state, updated at the accept edge
  ccf_framer u_framer (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .operation    (in_bus.operation),
    .data_byte    (in_bus.data_byte),
    .first_byte   (in_bus.first_byte),
    .last_byte    (in_bus.last_byte),
    .frame_header (frame_header),
    .bundle       (bundle)
  );

  // results leave one beat per cycle while out_ready is high, end_of_run on the last of a bundle
  ccf_result_buf u_rbuf (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (in_accept),
    .bundle      (bundle),
    .out_ready   (out_bus.ready),
    .out_valid   (out_bus.valid),
    .result_kind (out_bus.result_kind),
    .out_byte    (out_bus.out_byte),
    .crc_match   (out_bus.crc_match),
    .end_of_run  (out_bus.end_of_run),
    .can_load    (can_load)
  );
endmodule

// ===== rtl/core/ccf_apb_regs.sv =====
// apb-style configuration register (frame header) of the crc16 command framer
// depends on ccf_pkg
module ccf_apb_regs (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] frame_header
);
  import ccf_pkg::*;

  logic [15:0] header_r;
  logic [15:0] header_nxt;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_FRAME_HEADER);

  always_comb begin
    header_nxt = header_r;
    if (wr_en) begin
      header_nxt = pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= '0;
    end else begin
      header_r <= header_nxt;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FRAME_HEADER: prdata = {16'h0000, header_r};
      default:          prdata = '0;
    endcase
  end

  assign frame_header = header_r;
endmodule

// ===== rtl/core/ccf_framer.sv =====
// frame state (running crc, held bytes) and per-beat result bundle builder
// depends on ccf_pkg
module ccf_framer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic                 operation,
  input  logic [7:0]           data_byte,
  input  logic                 first_byte,
  input  logic                 last_byte,
  input  logic [15:0]          frame_header,
  output ccf_pkg::ccf_bundle_t bundle
);
  import ccf_pkg::*;

  logic [15:0] crc_r, crc_nxt;
  logic [15:0] held_r, held_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  logic [15:0] crc_base;
  logic [1:0]  cnt_base;
  logic [7:0]  fold_byte;
  logic [15:0] crc_fold_out;
  logic [15:0] crc_chk;
  logic [1:0]  cnt_new;
  logic [15:0] held_new;
  logic        match;

  assign crc_base  = first_byte ? 16'h0000 : crc_r;
  assign cnt_base  = first_byte ? 2'd0 : cnt_r;
  // one shared fold: payload byte when sending, oldest held byte when checking
  assign fold_byte    = (operation == OP_CHECK) ? held_r[15:8] : data_byte;
  assign crc_fold_out = crc_fold(crc_base, fold_byte);

  assign crc_chk  = (cnt_base == HELD_FULL) ? crc_fold_out : crc_base;
  assign cnt_new  = (cnt_base == HELD_FULL) ? HELD_FULL : cnt_base + 2'd1;
  assign held_new = {held_r[7:0], data_byte};
  // short frame passes
  assign match    = (cnt_new != HELD_FULL) || (held_new == crc_chk);

  always_comb begin
    crc_nxt  = crc_r;
    held_nxt = held_r;
    cnt_nxt  = cnt_r;
    bundle   = '0;
    if (operation == OP_TRANSMIT) begin
      bundle.kind = KIND_BYTE;
      if (first_byte) begin
        bundle.bytes[0] = frame_header[15:8];
        bundle.bytes[1] = frame_header[7:0];
        bundle.bytes[2] = data_byte;
        bundle.bytes[3] = crc_fold_out[15:8];
        bundle.bytes[4] = crc_fold_out[7:0];
        bundle.count    = last_byte ? CNT_W'(5) : CNT_W'(3);
      end else begin
        bundle.bytes[0] = data_byte;
        bundle.bytes[1] = crc_fold_out[15:8];
        bundle.bytes[2] = crc_fold_out[7:0];
        bundle.count    = last_byte ? CNT_W'(3) : CNT_W'(1);
      end
      if (accept) begin
        crc_nxt = last_byte ? 16'h0000 : crc_fold_out;
      end
    end else begin
      bundle.kind  = KIND_VERDICT;
      bundle.match = match;
      bundle.count = last_byte ? CNT_W'(1) : CNT_W'(0);
      if (accept) begin
        held_nxt = held_new;
        crc_nxt  = last_byte ? 16'h0000 : crc_chk;
        cnt_nxt  = last_byte ? 2'd0 : cnt_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= '0;
      held_r <= '0;
      cnt_r  <= '0;
    end else begin
      crc_r  <= crc_nxt;
      held_r <= held_nxt;
      cnt_r  <= cnt_nxt;
    end
  end
endmodule

// ===== rtl/core/ccf_result_buf.sv =====
// result register: holds one bundle and hands it out one beat per cycle while out_ready is high
// depends on ccf_pkg
module ccf_result_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  ccf_pkg::ccf_bundle_t bundle,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 result_kind,
  output logic [7:0]           out_byte,
  output logic                 crc_match,
  output logic                 end_of_run,
  output logic                 can_load
);
  import ccf_pkg::*;

  logic                        valid_r, valid_nxt;
  logic [CNT_W-1:0]            rem_r, rem_nxt;
  logic                        kind_r, kind_nxt;
  logic                        match_r, match_nxt;
  logic [MAX_RESULTS-1:0][7:0] bytes_r, bytes_nxt;
  logic                        pop;
  logic                        last_pop;

  assign pop      = valid_r && out_ready;
  assign last_pop = pop && (rem_r == CNT_W'(1));
  assign can_load = !valid_r || last_pop;

  always_comb begin
    valid_nxt = valid_r;
    rem_nxt   = rem_r;
    kind_nxt  = kind_r;
    match_nxt = match_r;
    bytes_nxt = bytes_r;
    if (pop) begin
      rem_nxt   = rem_r - CNT_W'(1);
      bytes_nxt = {8'h00, bytes_r[MAX_RESULTS-1:1]};
      if (last_pop) begin
        valid_nxt = 1'b0;
      end
    end
    if (load && (bundle.count != '0)) begin
      valid_nxt = 1'b1;
      rem_nxt   = bundle.count;
      kind_nxt  = bundle.kind;
      match_nxt = bundle.match;
      bytes_nxt = bundle.bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rem_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      rem_r   <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    match_r <= match_nxt;
    bytes_r <= bytes_nxt;
  end

  assign out_valid   = valid_r;
  assign result_kind = kind_r;
  assign out_byte    = bytes_r[0];
  assign crc_match   = match_r;
  assign end_of_run  = (rem_r == CNT_W'(1));
endmodule
